@@ rtl/core/smmp_pkg.sv @@
// Shared types, constants and codes of the segmented max / mean pooling unit.
// Depends on nothing; every module of the unit imports it.
package smmp_pkg;

	// Sizing of the unit.
	localparam int MAX_DIMS  = 64;
	localparam int MAX_NODES = 65536;

	localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCNT_W  = $clog2(MAX_DIMS + 1);
	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int FDIM_W  = 7;
	localparam int VAL_W   = 16;
	localparam int WIN_W   = 16;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 17;
	localparam int STEP_W  = $clog2(SUM_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = FDIM_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_MODE    = 1'b0,
		REG_FEATURE_DIMS = 1'b1
	} reg_index_t;

	typedef enum logic {
		MODE_MAX  = 1'b0,
		MODE_MEAN = 1'b1
	} pool_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_EMIT
	} state_t;

	// One accumulator entry per feature dimension.
	typedef struct packed {
		logic signed [VAL_W-1:0] max_val;
		logic [NODE_W-1:0]       arg_node;
		logic signed [SUM_W-1:0] sum;
	} acc_entry_t;

	// Request to the accumulator memory: one address per cycle.
	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [DIM_W-1:0] addr;
		acc_entry_t       wr_data;
	} mem_req_t;

	// Result of the divider.
	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] quotient;
	} div_res_t;

endpackage

@@ rtl/core/smmp_acc_mem.sv @@
// Accumulator memory of the pooling unit: one entry per feature dimension.
// Depends on smmp_pkg for the entry and request types.
module smmp_acc_mem import smmp_pkg::*; (
	input  logic       clk,
	input  mem_req_t   req,
	output acc_entry_t rd_data
);

	acc_entry_t mem_q [MAX_DIMS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.addr];
		end
	end

endmodule

@@ rtl/core/smmp_divider.sv @@
// Iterative restoring divider of the pooling unit, one quotient bit per cycle.
// Depends on smmp_pkg; the quotient is truncated toward zero and clamped to Q8.8.
module smmp_divider import smmp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output div_res_t                res
);

	localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(2 ** (VAL_W - 1) - 1);
	localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(2 ** (VAL_W - 1));

	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic                neg_q;
	logic [CNT_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic signed [VAL_W-1:0] result_q;

	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             take;
	logic [SUM_W-1:0] mag;

	// Magnitude of the dividend; the most negative sum maps to 2^31.
	assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

	// The one shared subtractor: partial remainder against the divisor.
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign take    = (shifted >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			div_q <= (divisor == '0) ? CNT_W'(1) : divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], take};
		end else if (fin_q) begin
			if (neg_q) begin
				result_q <= (quo_q > NEG_LIM) ? $signed(NEG_LIM[VAL_W-1:0])
					: $signed(VAL_W'(~quo_q + 1'b1));
			end else begin
				result_q <= (quo_q > POS_LIM) ? $signed(POS_LIM[VAL_W-1:0])
					: $signed(quo_q[VAL_W-1:0]);
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = result_q;

endmodule

@@ rtl/core/segmented_max_mean_pooling_unit.sv @@
// Top level of the segmented max / mean pooling unit: control sequencer and registers.
// Depends on smmp_pkg, smmp_acc_mem and smmp_divider.

// Feature elements of each node arrive one per request, in row-major order, and the
// unit pools every feature dimension over a segment of nodes. In max mode it returns
// the largest value with the global index of the node that first held it; in mean
// mode it returns the segment sum divided by the node count, truncated toward zero
// and clamped to Q8.8. Each element of a node flagged as ending its segment yields
// one result. A request that yields no result passes only through the update step;
// in max mode a result then goes to the emit step, and a mean result first waits on
// the divider, which produces one quotient bit per cycle over the 32-bit sum, before
// the emit step, which holds while the output register is stalled. While a request
// is in work in_stall is high, and the configuration port is ready only while idle.
// The accumulators live in a small memory with one registered read port, so the
// element is read in the accept cycle and written back in the next one.
module segmented_max_mean_pooling_unit import smmp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,

	// Configuration writes.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,

	// Element requests.
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [VAL_W-1:0] feature_value,
	input  logic                    node_ends_segment,
	input  logic                    batch_start,

	// Pooled results.
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] pooled_value,
	output logic [WIN_W-1:0]        winner_node,
	output logic [DIM_W-1:0]        dimension_index,
	output logic                    segment_done
);

	state_t state_q, state_d;

	// Configuration registers.
	pool_mode_t        pool_mode_q;
	logic [FDIM_W-1:0] feature_dims_q;

	// Running position in the stream.
	logic [DIM_W-1:0]  dim_q;
	logic [NODE_W-1:0] node_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              fresh_q;

	// The request in work.
	logic signed [VAL_W-1:0] val_q;
	logic                    ends_q;
	logic [DIM_W-1:0]        d_q;
	logic [NODE_W-1:0]       node_item_q;
	logic                    fresh_item_q;
	logic                    last_q;

	// Result waiting for the output register.
	logic signed [VAL_W-1:0] res_value_q;
	logic [WIN_W-1:0]        res_winner_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [WIN_W-1:0]        out_winner_q;
	logic [DIM_W-1:0]        out_dim_q;
	logic                    out_done_q;

	logic [DCNT_W-1:0] dcount;
	logic [31:0]       fd_wide;
	logic              in_acc;
	logic              out_free;

	// Position of an accepted request.
	logic [NODE_W-1:0] node_eff;
	logic [DIM_W-1:0]  dim_base;
	logic              fresh_eff;
	logic [CNT_W-1:0]  cnt_base;
	logic [DIM_W-1:0]  d_c;
	logic [CNT_W-1:0]  cnt_c;
	logic              last_c;
	logic [NODE_W-1:0] node_next_c;

	// Accumulator update.
	acc_entry_t        rd_data;
	acc_entry_t        upd_entry;
	logic signed [SUM_W:0] sum_wide;
	mem_req_t          mem_req;

	logic     div_start;
	div_res_t div_res;

	// Dimensions in use: zero acts as one, and the count is capped at the memory depth.
	always_comb begin
		fd_wide = 32'(feature_dims_q);
		if (fd_wide == 32'd0) begin
			fd_wide = 32'd1;
		end
		if (fd_wide > 32'(MAX_DIMS)) begin
			fd_wide = 32'(MAX_DIMS);
		end
		dcount = DCNT_W'(fd_wide);
	end

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// A batch start clears the position before the element is placed. A dimension
	// counter left at or beyond a lowered count restarts the node at dimension zero.
	always_comb begin
		node_eff  = batch_start ? '0 : node_q;
		dim_base  = batch_start ? '0 : dim_q;
		fresh_eff = batch_start ? 1'b1 : fresh_q;
		cnt_base  = batch_start ? '0 : cnt_q;
		d_c       = (DCNT_W'(dim_base) >= dcount) ? '0 : dim_base;
		cnt_c     = cnt_base;
		if (d_c == '0) begin
			if (fresh_eff) begin
				cnt_c = CNT_W'(1);
			end else if (cnt_base != COUNT_MAX) begin
				cnt_c = cnt_base + 1'b1;
			end
		end
		last_c      = ((DCNT_W'(d_c) + 1'b1) == dcount);
		node_next_c = (node_eff == NODE_W'(MAX_NODES - 1)) ? '0 : node_eff + 1'b1;
	end

	// New accumulator entry. A fresh segment starts over from this element; otherwise
	// a strictly greater value takes the maximum and the sum saturates at 32 bits.
	always_comb begin
		sum_wide  = $signed({rd_data.sum[SUM_W-1], rd_data.sum})
			+ $signed((SUM_W + 1)'(val_q));
		upd_entry = rd_data;
		if (fresh_item_q) begin
			upd_entry.max_val  = val_q;
			upd_entry.arg_node = node_item_q;
			upd_entry.sum      = SUM_W'(val_q);
		end else begin
			if (val_q > rd_data.max_val) begin
				upd_entry.max_val  = val_q;
				upd_entry.arg_node = node_item_q;
			end
			if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
				upd_entry.sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
					: {1'b0, {(SUM_W - 1){1'b1}}};
			end else begin
				upd_entry.sum = sum_wide[SUM_W-1:0];
			end
		end
	end

	smmp_acc_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	smmp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (upd_entry.sum),
		.divisor  (cnt_q),
		.res      (div_res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (!ends_q) begin
					state_d = ST_IDLE;
				end else if (pool_mode_q == MODE_MEAN) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: the memory reads in the accept cycle and writes back in the
	// next cycle, and a mean result kicks off the divider from the written sum.
	always_comb begin
		mem_req.rd_en   = 1'b0;
		mem_req.wr_en   = 1'b0;
		mem_req.addr    = d_c;
		mem_req.wr_data = upd_entry;
		div_start       = 1'b0;
		in_stall        = 1'b1;
		cfg_ready       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cfg_ready     = 1'b1;
				mem_req.rd_en = in_valid;
			end
			ST_UPD: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = d_q;
				div_start     = ends_q && (pool_mode_q == MODE_MEAN);
			end
			ST_DIV, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pool_mode_q    <= MODE_MAX;
			feature_dims_q <= FDIM_W'(1);
			dim_q          <= '0;
			node_q         <= '0;
			cnt_q          <= '0;
			fresh_q        <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_index_t'(cfg_index))
					REG_POOL_MODE:    pool_mode_q    <= pool_mode_t'(cfg_data[0]);
					REG_FEATURE_DIMS: feature_dims_q <= cfg_data[FDIM_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				cnt_q <= cnt_c;
				if (last_c) begin
					fresh_q <= node_ends_segment;
					node_q  <= node_next_c;
					dim_q   <= '0;
				end else begin
					fresh_q <= fresh_eff;
					node_q  <= node_eff;
					dim_q   <= d_c + 1'b1;
				end
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q        <= feature_value;
			ends_q       <= node_ends_segment;
			d_q          <= d_c;
			node_item_q  <= node_eff;
			fresh_item_q <= fresh_eff;
			last_q       <= last_c;
		end
		if (state_q == ST_UPD) begin
			res_value_q  <= upd_entry.max_val;
			res_winner_q <= (pool_mode_q == MODE_MEAN) ? '0 : WIN_W'(upd_entry.arg_node);
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			res_value_q <= div_res.quotient;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_value_q  <= res_value_q;
			out_winner_q <= res_winner_q;
			out_dim_q    <= d_q;
			out_done_q   <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign pooled_value    = out_value_q;
	assign winner_node     = out_winner_q;
	assign dimension_index = out_dim_q;
	assign segment_done    = out_done_q;

	// The divider answers only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider result outside of the divide wait");

	// A new result appears only after the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised without an emit step");

	// Every element being written back belongs to a segment of at least one node.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (cnt_q != '0))
		else $error("segment node count is zero during an update");

	// The dimension in work stays below the dimension count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (DCNT_W'(d_q) < dcount))
		else $error("dimension in work beyond the dimension count");

endmodule
